### design/assert_macros.svh
// assertion macros for the channel engine checker
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge
`define BCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/bce_pkg.sv
// shared constants, codes and controller/datapath structs of the channel engine
// used by bce_ctrl, bce_dpath, blocking_channel_engine and bce_checker
`default_nettype none
package bce_pkg;

  localparam int BUF_DEPTH   = 16;
  localparam int WAIT_DEPTH  = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ID_WIDTH    = 8;
  localparam int CAP_WIDTH   = 5;
  localparam int FUNC_WIDTH  = 3;
  localparam int ST_WIDTH    = 4;

  localparam int BUF_AW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int WAIT_AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int BCNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int WCNT_W  = $clog2(WAIT_DEPTH + 1);

  localparam int IN_DATA_W  = ((ID_WIDTH + VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_WIDTH + VALUE_WIDTH + 7) / 8) * 8;
  localparam int IN_USER_W  = 8;
  localparam int OUT_USER_W = 8;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FN_SEND     = 3'd0,
    FN_TRY_SEND = 3'd1,
    FN_RECV     = 3'd2,
    FN_TRY_RECV = 3'd3,
    FN_CLOSE    = 3'd4
  } func_t;

  typedef enum logic [ST_WIDTH-1:0] {
    ST_SENT         = 4'd0,
    ST_SEND_CLOSED  = 4'd1,
    ST_WOULD_BLOCK  = 4'd2,
    ST_RECEIVED     = 4'd3,
    ST_RECV_CLOSED  = 4'd4,
    ST_PARKED       = 4'd5,
    ST_CLOSE_CLOSED = 4'd6,
    ST_CLOSE_DONE   = 4'd7,
    ST_QUEUE_FULL   = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    TGT_REQ,
    TGT_SWAIT,
    TGT_RWAIT
  } tgt_sel_t;

  typedef enum logic [2:0] {
    VAL_ZERO,
    VAL_INPUT,
    VAL_RING,
    VAL_HOLD
  } val_sel_t;

  typedef struct packed {
    logic     load;
    logic     emit;
    tgt_sel_t tgt_sel;
    status_t  st;
    val_sel_t val_sel;
    logic     last;
    logic     ring_push;
    logic     push_from_swait;
    logic     ring_pop;
    logic     hold_en;
    logic     hold_from_swait;
    logic     s_push;
    logic     s_pop;
    logic     r_push;
    logic     r_pop;
    logic     set_closed;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_WIDTH-1:0] func;
    logic closed;
    logic ring_nz;
    logic ring_room;
    logic s_nz;
    logic s_full;
    logic r_nz;
    logic r_full;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/bce_ctrl.sv
// sequencer of the channel engine: decides each request and steps its results
// depends on bce_pkg; drives bce_dpath through cmd_t, reads sts_t
`default_nettype none
module bce_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  bce_pkg::sts_t      sts,
  output bce_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SECOND,
    S_CLOSE,
    S_CL_WAIT
  } state_t;

  state_t state_r, state_nxt;
  logic   sec_recv_r, sec_recv_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.tgt_sel  = bce_pkg::TGT_REQ;
    cmd.st       = bce_pkg::ST_SENT;
    cmd.val_sel  = bce_pkg::VAL_ZERO;
    state_nxt    = state_r;
    sec_recv_nxt = sec_recv_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (sts.func == bce_pkg::FN_SEND || sts.func == bce_pkg::FN_TRY_SEND) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
            priority if (sts.closed) begin
              cmd.st = bce_pkg::ST_SEND_CLOSED;
            end else if (sts.r_nz) begin
              cmd.tgt_sel  = bce_pkg::TGT_RWAIT;
              cmd.st       = bce_pkg::ST_RECEIVED;
              cmd.val_sel  = bce_pkg::VAL_INPUT;
              cmd.last     = 1'b0;
              cmd.r_pop    = 1'b1;
              sec_recv_nxt = 1'b0;
              state_nxt    = S_SECOND;
            end else if (sts.ring_room) begin
              cmd.ring_push = 1'b1;
              cmd.st        = bce_pkg::ST_SENT;
            end else if (sts.func == bce_pkg::FN_TRY_SEND) begin
              cmd.st = bce_pkg::ST_WOULD_BLOCK;
            end else if (sts.s_full) begin
              cmd.st = bce_pkg::ST_QUEUE_FULL;
            end else begin
              cmd.s_push = 1'b1;
              cmd.st     = bce_pkg::ST_PARKED;
            end
          end
        end else if (sts.func == bce_pkg::FN_RECV || sts.func == bce_pkg::FN_TRY_RECV) begin
          if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
            priority if (sts.ring_nz && sts.s_nz) begin
              cmd.tgt_sel         = bce_pkg::TGT_SWAIT;
              cmd.st              = bce_pkg::ST_SENT;
              cmd.last            = 1'b0;
              cmd.ring_pop        = 1'b1;
              cmd.hold_en         = 1'b1;
              cmd.s_pop           = 1'b1;
              cmd.ring_push       = 1'b1;
              cmd.push_from_swait = 1'b1;
              sec_recv_nxt        = 1'b1;
              state_nxt           = S_SECOND;
            end else if (sts.ring_nz) begin
              cmd.st       = bce_pkg::ST_RECEIVED;
              cmd.val_sel  = bce_pkg::VAL_RING;
              cmd.ring_pop = 1'b1;
            end else if (sts.s_nz) begin
              cmd.tgt_sel         = bce_pkg::TGT_SWAIT;
              cmd.st              = bce_pkg::ST_SENT;
              cmd.last            = 1'b0;
              cmd.hold_en         = 1'b1;
              cmd.hold_from_swait = 1'b1;
              cmd.s_pop           = 1'b1;
              sec_recv_nxt        = 1'b1;
              state_nxt           = S_SECOND;
            end else if (sts.closed) begin
              cmd.st = bce_pkg::ST_RECV_CLOSED;
            end else if (sts.func == bce_pkg::FN_TRY_RECV) begin
              cmd.st = bce_pkg::ST_WOULD_BLOCK;
            end else if (sts.r_full) begin
              cmd.st = bce_pkg::ST_QUEUE_FULL;
            end else begin
              cmd.r_push = 1'b1;
              cmd.st     = bce_pkg::ST_PARKED;
            end
          end
        end else if (sts.func == bce_pkg::FN_CLOSE) begin
          if (!sts.closed) begin
            cmd.set_closed = 1'b1;
            state_nxt      = S_CLOSE;
          end else if (sts.out_free) begin
            cmd.emit  = 1'b1;
            cmd.last  = 1'b1;
            cmd.st    = bce_pkg::ST_CLOSE_CLOSED;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SECOND: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          cmd.st    = sec_recv_r ? bce_pkg::ST_RECEIVED : bce_pkg::ST_SENT;
          cmd.val_sel = sec_recv_r ? bce_pkg::VAL_HOLD : bce_pkg::VAL_ZERO;
          state_nxt = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          priority if (sts.s_nz) begin
            cmd.tgt_sel = bce_pkg::TGT_SWAIT;
            cmd.st      = bce_pkg::ST_SEND_CLOSED;
            cmd.s_pop   = 1'b1;
            state_nxt   = S_CL_WAIT;
          end else if (sts.r_nz) begin
            cmd.tgt_sel = bce_pkg::TGT_RWAIT;
            cmd.st      = bce_pkg::ST_RECV_CLOSED;
            cmd.r_pop   = 1'b1;
            state_nxt   = S_CL_WAIT;
          end else begin
            cmd.st    = bce_pkg::ST_CLOSE_DONE;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_CL_WAIT: begin
        state_nxt = S_CLOSE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      sec_recv_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sec_recv_r <= sec_recv_nxt;
    end
  end

endmodule
`default_nettype wire

### design/bce_dpath.sv
// datapath of the channel engine: value ring, sender and receiver wait queues,
// closed flag, request latch and result register; depends on bce_pkg
`default_nettype none
module bce_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bce_pkg::CAP_WIDTH-1:0]   cfg_wr_data,
  input  wire logic [bce_pkg::FUNC_WIDTH-1:0]  in_func,
  input  wire logic [bce_pkg::ID_WIDTH-1:0]    in_requester,
  input  wire logic [bce_pkg::VALUE_WIDTH-1:0] in_value,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [bce_pkg::ID_WIDTH-1:0]         out_target,
  output logic [bce_pkg::ST_WIDTH-1:0]         out_status,
  output logic [bce_pkg::VALUE_WIDTH-1:0]      out_value,
  output logic                                 out_last,
  input  bce_pkg::cmd_t                        cmd,
  output bce_pkg::sts_t                        sts
);

  localparam int VW = bce_pkg::VALUE_WIDTH;
  localparam int IW = bce_pkg::ID_WIDTH;

  logic [VW-1:0] ring_mem [bce_pkg::BUF_DEPTH];
  logic [IW-1:0] sw_id_mem [bce_pkg::WAIT_DEPTH];
  logic [VW-1:0] sw_val_mem [bce_pkg::WAIT_DEPTH];
  logic [IW-1:0] rw_id_mem [bce_pkg::WAIT_DEPTH];

  logic [VW-1:0] ring_rd_r, sw_val_rd_r;
  logic [IW-1:0] sw_id_rd_r, rw_id_rd_r;

  logic [bce_pkg::CAP_WIDTH-1:0]  cap_r;
  logic [bce_pkg::BUF_AW-1:0]     ring_head_r, ring_tail_r;
  logic [bce_pkg::BCNT_W-1:0]     ring_cnt_r;
  logic [bce_pkg::WAIT_AW-1:0]    s_head_r, s_tail_r, r_head_r, r_tail_r;
  logic [bce_pkg::WCNT_W-1:0]     s_cnt_r, r_cnt_r;
  logic                           closed_r;

  logic [bce_pkg::FUNC_WIDTH-1:0] func_r;
  logic [IW-1:0]                  req_r;
  logic [VW-1:0]                  val_r, hold_r, push_val;

  logic                           out_valid_r, out_last_r;
  logic [IW-1:0]                  out_tgt_r;
  logic [bce_pkg::ST_WIDTH-1:0]   out_st_r;
  logic [VW-1:0]                  out_val_r;
  logic                           out_free;

  function automatic logic [bce_pkg::BUF_AW-1:0] buf_inc(input logic [bce_pkg::BUF_AW-1:0] p);
    return (32'(p) == bce_pkg::BUF_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [bce_pkg::WAIT_AW-1:0] wait_inc(
    input logic [bce_pkg::WAIT_AW-1:0] p);
    return (32'(p) == bce_pkg::WAIT_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign push_val = cmd.push_from_swait ? sw_val_rd_r : val_r;

  always_comb begin
    sts.func      = func_r;
    sts.closed    = closed_r;
    sts.ring_nz   = (ring_cnt_r != '0);
    sts.ring_room = (32'(cap_r) > bce_pkg::BUF_DEPTH) ?
                    (32'(ring_cnt_r) < bce_pkg::BUF_DEPTH) :
                    (32'(ring_cnt_r) < 32'(cap_r));
    sts.s_nz      = (s_cnt_r != '0);
    sts.s_full    = (32'(s_cnt_r) >= bce_pkg::WAIT_DEPTH);
    sts.r_nz      = (r_cnt_r != '0);
    sts.r_full    = (32'(r_cnt_r) >= bce_pkg::WAIT_DEPTH);
    sts.out_free  = out_free;
  end

  // memories, registered reads at the queue heads
  always_ff @(posedge clk) begin
    ring_rd_r   <= ring_mem[ring_head_r];
    sw_id_rd_r  <= sw_id_mem[s_head_r];
    sw_val_rd_r <= sw_val_mem[s_head_r];
    rw_id_rd_r  <= rw_id_mem[r_head_r];
    if (cmd.ring_push) begin
      ring_mem[ring_tail_r] <= push_val;
    end
    if (cmd.s_push) begin
      sw_id_mem[s_tail_r]  <= req_r;
      sw_val_mem[s_tail_r] <= val_r;
    end
    if (cmd.r_push) begin
      rw_id_mem[r_tail_r] <= req_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      req_r  <= in_requester;
      val_r  <= in_value;
    end
    if (cmd.hold_en) begin
      hold_r <= cmd.hold_from_swait ? sw_val_rd_r : ring_rd_r;
    end
    if (cmd.emit) begin
      out_last_r <= cmd.last;
      out_st_r   <= cmd.st;
      unique case (cmd.tgt_sel)
        bce_pkg::TGT_SWAIT: out_tgt_r <= sw_id_rd_r;
        bce_pkg::TGT_RWAIT: out_tgt_r <= rw_id_rd_r;
        default:            out_tgt_r <= req_r;
      endcase
      unique case (cmd.val_sel)
        bce_pkg::VAL_INPUT: out_val_r <= val_r;
        bce_pkg::VAL_RING:  out_val_r <= ring_rd_r;
        bce_pkg::VAL_HOLD:  out_val_r <= hold_r;
        default:            out_val_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      ring_head_r <= '0;
      ring_tail_r <= '0;
      ring_cnt_r  <= '0;
      s_head_r    <= '0;
      s_tail_r    <= '0;
      s_cnt_r     <= '0;
      r_head_r    <= '0;
      r_tail_r    <= '0;
      r_cnt_r     <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (cmd.ring_push) begin
        ring_tail_r <= buf_inc(ring_tail_r);
      end
      if (cmd.ring_pop) begin
        ring_head_r <= buf_inc(ring_head_r);
      end
      if (cmd.ring_push && !cmd.ring_pop) begin
        ring_cnt_r <= ring_cnt_r + 1'b1;
      end else if (cmd.ring_pop && !cmd.ring_push) begin
        ring_cnt_r <= ring_cnt_r - 1'b1;
      end
      if (cmd.s_push) begin
        s_tail_r <= wait_inc(s_tail_r);
        s_cnt_r  <= s_cnt_r + 1'b1;
      end else if (cmd.s_pop) begin
        s_head_r <= wait_inc(s_head_r);
        s_cnt_r  <= s_cnt_r - 1'b1;
      end
      if (cmd.r_push) begin
        r_tail_r <= wait_inc(r_tail_r);
        r_cnt_r  <= r_cnt_r + 1'b1;
      end else if (cmd.r_pop) begin
        r_head_r <= wait_inc(r_head_r);
        r_cnt_r  <= r_cnt_r - 1'b1;
      end
      if (cmd.set_closed) begin
        closed_r <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_target = out_tgt_r;
  assign out_status = out_st_r;
  assign out_value  = out_val_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

### design/blocking_channel_engine.sv
// top level of the blocking channel engine: stream ports, config write port
// instantiates bce_ctrl and bce_dpath; depends on bce_pkg
//
// Requests (send, try send, receive, try receive, close) are taken one at a
// time. A request is accepted in the idle state, then decided in the decide
// state, where a send or receive waits for a free output register. Its results
// leave through that single output register, the issuer's own result last with
// tlast set; a new request is accepted only after its last result is issued.
// A close wakes each waiter in turn, with a wait state between pops for the
// registered read at the head of the wait queue. No reset sweep is needed.
`default_nettype none
module blocking_channel_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bce_pkg::CAP_WIDTH-1:0]     cfg_wr_data,  // buffer_capacity
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bce_pkg::IN_DATA_W-1:0]     in_tdata,   // requester, value
  input  wire logic [bce_pkg::IN_USER_W-1:0]     in_tuser,   // func, zero fill
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [bce_pkg::OUT_DATA_W-1:0]         out_tdata,  // target, value
  output logic [bce_pkg::OUT_USER_W-1:0]         out_tuser,  // status, zero fill
  output logic                                   out_tlast
);

  localparam int IW = bce_pkg::ID_WIDTH;
  localparam int VW = bce_pkg::VALUE_WIDTH;

  bce_pkg::cmd_t cmd;
  bce_pkg::sts_t sts;

  logic [IW-1:0]                 out_target;
  logic [VW-1:0]                 out_value;
  logic [bce_pkg::ST_WIDTH-1:0]  out_status;

  bce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bce_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_func      (in_tuser[bce_pkg::FUNC_WIDTH-1:0]),
    .in_requester (in_tdata[IW-1:0]),
    .in_value     (in_tdata[IW+VW-1:IW]),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_target   (out_target),
    .out_status   (out_status),
    .out_value    (out_value),
    .out_last     (out_tlast),
    .cmd          (cmd),
    .sts          (sts)
  );

  assign out_tdata = bce_pkg::OUT_DATA_W'({out_value, out_target});
  assign out_tuser = bce_pkg::OUT_USER_W'(out_status);

endmodule
`default_nettype wire

### design/bce_checker.sv
// port-level checks of the blocking channel engine, bound to the top level
// depends on bce_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module bce_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [bce_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic [bce_pkg::OUT_USER_W-1:0] out_tuser,
  input wire logic                          out_tlast
);

  `BCE_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "accepted while busy")
  `BCE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")
  `BCE_ASSERT(a_status_range, out_tvalid |-> out_tuser <= bce_pkg::OUT_USER_W'(bce_pkg::ST_QUEUE_FULL), "status out of range")
  `BCE_ASSERT(a_waiter_status, out_tvalid && !out_tlast |-> out_tuser == bce_pkg::OUT_USER_W'(bce_pkg::ST_SENT) || out_tuser == bce_pkg::OUT_USER_W'(bce_pkg::ST_RECEIVED) || out_tuser == bce_pkg::OUT_USER_W'(bce_pkg::ST_SEND_CLOSED) || out_tuser == bce_pkg::OUT_USER_W'(bce_pkg::ST_RECV_CLOSED), "bad waiter status")
  `BCE_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind blocking_channel_engine bce_checker u_bce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire
